/* design/cscan_pkg.sv */
package cscan_pkg;

   localparam int BLOCK_COUNT    = 1024;
   localparam int SLOT_COUNT_DEF = 16;

   localparam int BLK_W  = 10;
   localparam int CNT_W  = 5;
   localparam int STAT_W = 2;

   // head after reset: half the disk, kept to the block field width
   localparam logic [BLK_W-1:0] HEAD_RESET = BLK_W'(BLOCK_COUNT / 2);

   localparam logic REQ_SUBMIT  = 1'b0;
   localparam logic REQ_SERVICE = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_SERVED   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ACCEPTED = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic valid_set;
      logic valid_clr;
   } tbl_ctl_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [BLK_W-1:0]  served_block;
      logic [CNT_W-1:0]  removed_count;
      logic [BLK_W-1:0]  head_position;
      logic [CNT_W-1:0]  pending_count;
   } rsp_type;

endpackage

/* design/cscan_chan_if.sv */
interface cscan_req_if;
   import cscan_pkg::*;

   logic             valid;
   logic             ready;
   logic             req_type;
   logic [BLK_W-1:0] block;

   modport source (output valid, output req_type, output block, input ready);
   modport sink   (input valid, input req_type, input block, output ready);
endinterface

interface cscan_rsp_if;
   import cscan_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [BLK_W-1:0]  served_block;
   logic [CNT_W-1:0]  removed_count;
   logic [BLK_W-1:0]  head_position;
   logic [CNT_W-1:0]  pending_count;

   modport source (output valid, output status, output served_block, output removed_count,
                   output head_position, output pending_count, input ready);
   modport sink   (input valid, input status, input served_block, input removed_count,
                   input head_position, input pending_count, output ready);
endinterface

/* design/cscan_slot_table.sv */
module cscan_slot_table #(
   parameter int SLOT_COUNT = cscan_pkg::SLOT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cscan_pkg::tbl_ctl_type        ctl,
   input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
   input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
   input  logic [cscan_pkg::BLK_W-1:0]   wr_data,
   output logic [cscan_pkg::BLK_W-1:0]   rd_data,
   output logic                          rd_valid
);
   import cscan_pkg::*;

   logic [BLK_W-1:0]      mem_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [BLK_W-1:0]      rd_data_ff;
   logic                  rd_valid_ff;

   // block numbers: plain synchronous RAM, one write and one read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // occupancy flags, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.valid_set) begin
         valid_ff[wr_addr] <= 1'b1;
      end else if (ctl.valid_clr) begin
         valid_ff[wr_addr] <= 1'b0;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

/* design/cscan_sched_fsm.sv */
module cscan_sched_fsm #(
   parameter int SLOT_COUNT = cscan_pkg::SLOT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_type,
   input  logic [cscan_pkg::BLK_W-1:0]   in_block,
   output logic                          res_valid,
   input  logic                          res_ready,
   output cscan_pkg::rsp_type            res_data,
   output cscan_pkg::tbl_ctl_type        tbl_ctl,
   output logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
   output logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
   output logic [cscan_pkg::BLK_W-1:0]   wr_data,
   input  logic [cscan_pkg::BLK_W-1:0]   rd_data,
   input  logic                          rd_valid
);
   import cscan_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CW    = IDX_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_FREE = 3'd2;
   localparam logic [2:0] ST_SUB  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     iss_ff, iss_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [BLK_W-1:0]  head_ff, head_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [BLK_W-1:0]  best_all_ff, best_all_in;
   logic              have_any_ff, have_any_in;
   logic [BLK_W-1:0]  best_abv_ff, best_abv_in;
   logic              have_abv_ff, have_abv_in;
   logic [BLK_W-1:0]  pick_ff, pick_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic issue_ok;
   logic last;
   logic hit;

   assign issue_ok = (iss_ff != CW'(SLOT_COUNT));
   assign last     = pend_ff && (pidx_ff == IDX_W'(SLOT_COUNT - 1));
   assign hit      = pend_ff && rd_valid;

   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in    = state_ff;
      iss_in      = iss_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      blk_in      = blk_ff;
      head_in     = head_ff;
      occ_in      = occ_ff;
      best_all_in = best_all_ff;
      have_any_in = have_any_ff;
      best_abv_in = best_abv_ff;
      have_abv_in = have_abv_ff;
      pick_in     = pick_ff;
      rem_in      = rem_ff;
      status_in   = status_ff;
      tbl_ctl     = '0;
      rd_addr     = iss_ff[IDX_W-1:0];
      wr_addr     = pidx_ff;
      wr_data     = blk_ff;

      // one slot read issued per cycle while a pass is running, until every slot has been issued
      if ((state_ff == ST_SCAN || state_ff == ST_FREE || state_ff == ST_SUB) && issue_ok) begin
         tbl_ctl.rd_en = 1'b1;
         iss_in        = iss_ff + 1'b1;
         pend_in       = 1'b1;
         pidx_in       = iss_ff[IDX_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               blk_in      = in_block;
               iss_in      = '0;
               have_any_in = 1'b0;
               have_abv_in = 1'b0;
               rem_in      = '0;
               pick_in     = '0;
               state_in    = (in_type == REQ_SERVICE) ? ST_SCAN : ST_SUB;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               if (!have_any_ff || rd_data < best_all_ff) begin
                  best_all_in = rd_data;
                  have_any_in = 1'b1;
               end
               if (rd_data > head_ff && (!have_abv_ff || rd_data < best_abv_ff)) begin
                  best_abv_in = rd_data;
                  have_abv_in = 1'b1;
               end
            end
            if (last) begin
               if (!have_any_in) begin
                  status_in = STATUS_EMPTY;
                  state_in  = ST_DONE;
               end else begin
                  pick_in  = have_abv_in ? best_abv_in : best_all_in;
                  iss_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_FREE;
               end
            end
         end
         ST_FREE: begin
            if (hit && rd_data == pick_ff) begin
               tbl_ctl.valid_clr = 1'b1;
               rem_in            = rem_ff + 1'b1;
            end
            if (last) begin
               head_in   = pick_ff;
               occ_in    = occ_ff - rem_in;
               status_in = STATUS_SERVED;
               state_in  = ST_DONE;
            end
         end
         ST_SUB: begin
            if (pend_ff && !rd_valid) begin
               // lowest free slot found
               tbl_ctl.wr_en     = 1'b1;
               tbl_ctl.valid_set = 1'b1;
               occ_in            = occ_ff + 1'b1;
               status_in         = STATUS_ACCEPTED;
               state_in          = ST_DONE;
            end else if (last) begin
               status_in = STATUS_FULL;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         head_ff  <= HEAD_RESET;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff      <= iss_in;
      pidx_ff     <= pidx_in;
      blk_ff      <= blk_in;
      best_all_ff <= best_all_in;
      have_any_ff <= have_any_in;
      best_abv_ff <= best_abv_in;
      have_abv_ff <= have_abv_in;
      pick_ff     <= pick_in;
      rem_ff      <= rem_in;
      status_ff   <= status_in;
   end

   assign res_data.status        = status_ff;
   assign res_data.served_block  = pick_ff;
   assign res_data.removed_count = CNT_W'(rem_ff);
   assign res_data.head_position = head_ff;
   assign res_data.pending_count = CNT_W'(occ_ff);

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(SLOT_COUNT))
      else $error("pending count above slot count");

   a_served_removes: assert property (@(posedge clock) disable iff (reset)
      (res_valid && status_ff == STATUS_SERVED) |-> (rem_ff != '0))
      else $error("served request freed no slot");

   a_head_follows: assert property (@(posedge clock) disable iff (reset)
      (res_valid && status_ff == STATUS_SERVED) |-> (head_ff == pick_ff))
      else $error("head not at served block");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff == ST_SCAN || state_ff == ST_SUB))
      else $error("accepted request did not start a pass");

   a_submit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUB && pend_ff && !rd_valid) |=>
         (occ_ff == CW'($past(occ_ff) + 1'b1)))
      else $error("submit did not bump pending count");

endmodule

/* design/cscan_disk_request_scheduler_top.sv */
// C-SCAN disk request scheduler.
// A submit stops at the lowest free slot, or after the last slot when the table is full.
// One request at a time; rate is set by the slot RAM read port, one slot per cycle:
// a service sweeps the table twice (find, then free), once if it is empty; a submit once at most.
// Synchronous active-high reset: table empty, head at half the block count.
module cscan_disk_request_scheduler_top #(
   parameter int SLOT_COUNT = cscan_pkg::SLOT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cscan_req_if.sink   req_chan,
   cscan_rsp_if.source rsp_chan
);
   import cscan_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);

   // sequencer <-> slot table
   tbl_ctl_type      tbl_ctl;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [BLK_W-1:0] wr_data;
   logic [BLK_W-1:0] rd_data;
   logic             rd_valid;

   // sequencer -> response register
   logic    res_valid;
   logic    res_ready;
   rsp_type res_data;

   // response register: lets the sequencer go back to idle and take the next
   // request while the previous response still waits downstream
   logic    out_vld_ff;
   rsp_type out_data_ff;

   cscan_sched_fsm #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_type   (req_chan.req_type),
      .in_block  (req_chan.block),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .tbl_ctl   (tbl_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data),
      .rd_valid  (rd_valid)
   );

   cscan_slot_table #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

   // register is free when empty or being drained this cycle
   assign res_ready = !out_vld_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_data_ff <= res_data;
      end
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.status        = out_data_ff.status;
   assign rsp_chan.served_block  = out_data_ff.served_block;
   assign rsp_chan.removed_count = out_data_ff.removed_count;
   assign rsp_chan.head_position = out_data_ff.head_position;
   assign rsp_chan.pending_count = out_data_ff.pending_count;

endmodule
